>>> src/rat_pkg.sv
// ----------------------------------------------------------------------------
// rat_pkg
// Types and codes shared by the region address translation table files.
// ----------------------------------------------------------------------------
package rat_pkg;

  // Command codes of an input beat.
  localparam logic [2:0] CMD_REGISTER   = 3'd0;
  localparam logic [2:0] CMD_UPDATE     = 3'd1;
  localparam logic [2:0] CMD_UNREGISTER = 3'd2;
  localparam logic [2:0] CMD_CLEAR      = 3'd3;
  localparam logic [2:0] CMD_CHECK      = 3'd4;
  localparam logic [2:0] CMD_V2P        = 3'd5;
  localparam logic [2:0] CMD_P2V        = 3'd6;
  // The one code with no command behind it; it is refused.
  localparam logic [2:0] CMD_UNUSED     = 3'd7;

  // Status codes of a result beat.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_INVAL = 2'd1;
  localparam logic [1:0] STAT_MISS  = 2'd2;
  localparam logic [1:0] STAT_FULL  = 2'd3;

  // One table entry: the key base, the base of the other space and the size.
  typedef struct packed {
    logic [63:0] key;
    logic [63:0] other;
    logic [63:0] bytes;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  // One result beat handed from the controller to the output register.
  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] addr;
    logic [63:0] bytes;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_V,
    ST_SCAN_P,
    ST_DECIDE,
    ST_CALC1,
    ST_CALC2,
    ST_CALC3,
    ST_DONE
  } state_t;

endpackage

>>> src/rat_ram.sv
// ----------------------------------------------------------------------------
// rat_ram
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module rat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/rat_ctrl.sv
// ----------------------------------------------------------------------------
// rat_ctrl
// Command sequencer: scans both tables, decides, writes back and computes
// the translated address and clipped length.
// ----------------------------------------------------------------------------
module rat_ctrl #(
  parameter int TABLE_ENTRIES = 16,
  parameter int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_command,
  input  logic [63:0]         in_virt_addr,
  input  logic [63:0]         in_phys_addr,
  input  logic [63:0]         in_byte_count,
  output logic [IW-1:0]       v_raddr,
  output logic                v_we,
  output logic [IW-1:0]       v_waddr,
  output rat_pkg::ent_t       v_wdata,
  input  rat_pkg::ent_t       v_rdata,
  output logic [IW-1:0]       p_raddr,
  output logic                p_we,
  output logic [IW-1:0]       p_waddr,
  output rat_pkg::ent_t       p_wdata,
  input  rat_pkg::ent_t       p_rdata,
  output logic                res_valid,
  output rat_pkg::res_t       res_o,
  input  logic                res_take
);
  import rat_pkg::*;

  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  state_t state_r, state_nxt;

  logic [2:0]  cmd_r;
  logic [63:0] va_r, pa_r, n_r, sum_r;
  logic [CW-1:0] cnt_r;
  logic          pv_r;
  logic [IW-1:0] pidx_r;
  logic [TABLE_ENTRIES-1:0] vvalid_r, pvalid_r;

  // Search results.
  logic          vm_found_r, vf_found_r, nx_found_r, fl_found_r;
  logic          pm_found_r, pn_found_r, pf_found_r;
  logic [IW-1:0] vm_idx_r, vf_idx_r, pm_idx_r, pn_idx_r, pf_idx_r;
  logic [63:0]   vm_pbase_r, pm_vbase_r, nx_key_r;
  ent_t          fl_r;
  logic [63:0]   off_r, room_r;

  logic [1:0]  res_status_r;
  logic [63:0] res_addr_r, res_bytes_r;

  logic   accept, scan_end, cur_valid, en_fl;
  ent_t   cur;
  logic [63:0] fl_addr;

  // Decision outputs.
  logic [1:0]    dec_status;
  logic          v_clr, v_set, p_clr, p_set;
  logic [IW-1:0] v_cidx, v_sidx, p_cidx, p_sidx;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);
  assign v_raddr  = cnt_r[IW-1:0];
  assign p_raddr  = cnt_r[IW-1:0];
  assign scan_end = (cnt_r == CW'(TABLE_ENTRIES));

  // The entry read in the previous cycle and whether it holds a region.
  assign cur       = (state_r == ST_SCAN_V) ? v_rdata : p_rdata;
  assign cur_valid = (state_r == ST_SCAN_V) ? vvalid_r[pidx_r] : pvalid_r[pidx_r];
  assign en_fl     = ((state_r == ST_SCAN_V) && ((cmd_r == CMD_CHECK) || (cmd_r == CMD_V2P)))
                  || ((state_r == ST_SCAN_P) && (cmd_r == CMD_P2V));
  assign fl_addr   = (cmd_r == CMD_P2V) ? pa_r : va_r;

  assign res_valid = (state_r == ST_DONE);
  assign res_o     = '{status: res_status_r, addr: res_addr_r, bytes: res_bytes_r};

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state, decision and table writes.
  always_comb begin
    state_nxt  = state_r;
    dec_status = STAT_OK;
    v_we = 1'b0; v_waddr = '0; v_wdata = '{key: va_r, other: pa_r, bytes: n_r};
    p_we = 1'b0; p_waddr = '0; p_wdata = '{key: pa_r, other: va_r, bytes: n_r};
    v_clr = 1'b0; v_set = 1'b0; p_clr = 1'b0; p_set = 1'b0;
    v_cidx = vm_idx_r; v_sidx = vf_idx_r; p_cidx = pm_idx_r;
    p_sidx = pn_found_r ? pn_idx_r : pf_idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_command == CMD_CLEAR) ? ST_DONE : ST_SCAN_V;
        end
      end
      ST_SCAN_V: begin
        if (scan_end) state_nxt = ST_SCAN_P;
      end
      ST_SCAN_P: begin
        if (scan_end) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_nxt = ST_DONE;
        unique case (cmd_r)
          CMD_REGISTER: begin
            priority if (vm_found_r) begin
              dec_status = STAT_OK;
            end else if (nx_found_r && (sum_r > nx_key_r)) begin
              dec_status = STAT_INVAL;
            end else if (!vf_found_r || (!pn_found_r && !pf_found_r)) begin
              dec_status = STAT_FULL;
            end else begin
              v_we = 1'b1; v_waddr = vf_idx_r; v_set = 1'b1;
              p_we = 1'b1; p_waddr = p_sidx;   p_set = 1'b1;
            end
          end
          CMD_UPDATE: begin
            priority if (!vm_found_r || !pm_found_r) begin
              dec_status = STAT_INVAL;
            end else if (vm_pbase_r == pa_r) begin
              v_we = 1'b1; v_waddr = vm_idx_r;
              p_we = 1'b1; p_waddr = pm_idx_r;
              p_wdata = '{key: pa_r, other: pm_vbase_r, bytes: n_r};
            end else begin
              v_we = 1'b1; v_waddr = vm_idx_r;
              p_clr = 1'b1;
              p_sidx = pn_found_r ? pn_idx_r : pm_idx_r;
              p_we = 1'b1; p_waddr = p_sidx; p_set = 1'b1;
            end
          end
          CMD_UNREGISTER: begin
            if (!vm_found_r) begin
              dec_status = STAT_MISS;
            end else begin
              v_clr = 1'b1;
              p_clr = pm_found_r;
            end
          end
          CMD_CHECK, CMD_V2P, CMD_P2V: begin
            if (!fl_found_r) begin
              dec_status = STAT_MISS;
            end else begin
              state_nxt = ST_CALC1;
            end
          end
          default: dec_status = STAT_INVAL;
        endcase
      end
      ST_CALC1: state_nxt = ST_CALC2;
      ST_CALC2: begin
        state_nxt = ((off_r < fl_r.bytes) && (cmd_r == CMD_V2P)) ? ST_CALC3 : ST_DONE;
      end
      ST_CALC3: state_nxt = ST_DONE;
      ST_DONE: begin
        if (res_take) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Valid bits live in flip-flops; a clear of all regions is immediate.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vvalid_r <= '0;
      pvalid_r <= '0;
    end else if (accept && (in_command == CMD_CLEAR)) begin
      vvalid_r <= '0;
      pvalid_r <= '0;
    end else if (state_r == ST_DECIDE) begin
      if (v_clr) vvalid_r[v_cidx] <= 1'b0;
      if (v_set) vvalid_r[v_sidx] <= 1'b1;
      if (p_clr) pvalid_r[p_cidx] <= 1'b0;
      if (p_set) pvalid_r[p_sidx] <= 1'b1;
    end
  end

  // Scan counter and the pipeline flag for the registered read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      pv_r  <= 1'b0;
    end else if ((state_r == ST_SCAN_V) || (state_r == ST_SCAN_P)) begin
      pidx_r <= cnt_r[IW-1:0];
      if (scan_end) begin
        cnt_r <= '0;
        pv_r  <= 1'b0;
      end else begin
        cnt_r <= cnt_r + CW'(1);
        pv_r  <= 1'b1;
      end
    end else begin
      cnt_r <= '0;
      pv_r  <= 1'b0;
    end
  end

  // Command capture and the search over each table entry in turn.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_command;
      va_r  <= in_virt_addr;
      pa_r  <= in_phys_addr;
      n_r   <= in_byte_count;
      sum_r <= in_virt_addr + in_byte_count;
      vm_found_r <= 1'b0; vf_found_r <= 1'b0; nx_found_r <= 1'b0;
      fl_found_r <= 1'b0; pm_found_r <= 1'b0; pn_found_r <= 1'b0;
      pf_found_r <= 1'b0;
    end else if (pv_r && (state_r == ST_SCAN_V)) begin
      if (!cur_valid && !vf_found_r) begin
        vf_found_r <= 1'b1;
        vf_idx_r   <= pidx_r;
      end
      if (cur_valid && (cur.key == va_r) && !vm_found_r) begin
        vm_found_r <= 1'b1;
        vm_idx_r   <= pidx_r;
        vm_pbase_r <= cur.other;
      end
      if (cur_valid && (cur.key > va_r) && (!nx_found_r || (cur.key < nx_key_r))) begin
        nx_found_r <= 1'b1;
        nx_key_r   <= cur.key;
      end
    end else if (pv_r && (state_r == ST_SCAN_P)) begin
      if (!cur_valid && !pf_found_r) begin
        pf_found_r <= 1'b1;
        pf_idx_r   <= pidx_r;
      end
      if (cur_valid && vm_found_r && (cur.key == vm_pbase_r) && !pm_found_r) begin
        pm_found_r <= 1'b1;
        pm_idx_r   <= pidx_r;
        pm_vbase_r <= cur.other;
      end
      if (cur_valid && (cur.key == pa_r) && !pn_found_r) begin
        pn_found_r <= 1'b1;
        pn_idx_r   <= pidx_r;
      end
    end
    // Floor search shares its registers between the two tables.
    if (!accept && pv_r && en_fl && cur_valid && (cur.key <= fl_addr)
        && (!fl_found_r || (cur.key > fl_r.key))) begin
      fl_found_r <= 1'b1;
      fl_r       <= cur;
    end
  end

  // Result registers and the offset arithmetic of the CALC states.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        res_status_r <= STAT_OK;
        res_addr_r   <= '0;
        res_bytes_r  <= '0;
      end
      ST_DECIDE: res_status_r <= dec_status;
      ST_CALC1:  off_r <= fl_addr - fl_r.key;
      ST_CALC2: begin
        if (off_r >= fl_r.bytes) begin
          res_status_r <= STAT_MISS;
        end else begin
          room_r <= fl_r.bytes - off_r;
          if (cmd_r != CMD_CHECK) res_addr_r <= fl_r.other + off_r;
        end
      end
      ST_CALC3:  res_bytes_r <= (n_r > room_r) ? room_r : n_r;
      default: ;
    endcase
  end

endmodule

>>> src/region_address_translation_table_core.sv
// ----------------------------------------------------------------------------
// region_address_translation_table_core
// Two region tables mapping virtual to physical address ranges and back.
// ----------------------------------------------------------------------------
// Each command beat is taken alone: after acceptance in_stall stays high
// until its result is in the output register. A command scans the virtual
// table and then the physical table, one entry a cycle through the read port
// of each table RAM, and then decides; check and translations that find a
// region go on to the offset arithmetic, while clear all goes straight to
// its result. A new command is accepted while the previous result still
// waits on out_stall.
module region_address_translation_table_core #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [63:0] in_virt_addr,
  input  logic [63:0] in_phys_addr,
  input  logic [63:0] in_byte_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [63:0] out_addr,
  output logic [63:0] out_bytes
);
  import rat_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [IW-1:0] v_raddr, v_waddr, p_raddr, p_waddr;
  logic          v_we, p_we;
  ent_t          v_wdata, v_rdata, p_wdata, p_rdata;
  logic          res_valid, res_take;
  res_t          res;
  logic          out_valid_r;
  res_t          out_r;

  rat_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_ENTRIES)) u_vtab (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(v_rdata)
  );

  rat_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_ENTRIES)) u_ptab (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  rat_ctrl #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_virt_addr(in_virt_addr), .in_phys_addr(in_phys_addr),
    .in_byte_count(in_byte_count),
    .v_raddr(v_raddr), .v_we(v_we), .v_waddr(v_waddr), .v_wdata(v_wdata),
    .v_rdata(v_rdata),
    .p_raddr(p_raddr), .p_we(p_we), .p_waddr(p_waddr), .p_wdata(p_wdata),
    .p_rdata(p_rdata),
    .res_valid(res_valid), .res_o(res), .res_take(res_take)
  );

  // Output register: loads a finished result whenever it is empty or drains.
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) out_r <= res;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_r.status;
  assign out_addr   = out_r.addr;
  assign out_bytes  = out_r.bytes;

endmodule

>>> src/rat_checker.sv
// ----------------------------------------------------------------------------
// rat_checker
// Port-level checks on the region address translation table.
// ----------------------------------------------------------------------------
module rat_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [63:0] out_addr,
  input logic [63:0] out_bytes
);
  import rat_pkg::*;

  // Only one command is in work at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("command accepted while another was in work");

  // A failed command never reports an address or a length.
  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STAT_OK)) |-> ((out_addr == '0) && (out_bytes == '0)))
    else $error("non-zero outputs on a failed command");

  // A result beat is held while stalled.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result beat dropped under stall");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present after reset");

endmodule

bind region_address_translation_table_core rat_checker u_rat_checker (.*);

>>> dv/region_address_translation_table_core_tb.sv
// ----------------------------------------------------------------------------
// region_address_translation_table_core_tb
// Drives command beats into the region translation tables and compares every
// result beat with a predictor that keeps its own copy of both tables.
// ----------------------------------------------------------------------------
module region_address_translation_table_core_tb;
  import rat_pkg::*;

  localparam int ENTRIES = 16;

  typedef struct {
    logic [1:0]  status;
    logic [63:0] addr;
    logic [63:0] bytes;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_command = CMD_CLEAR;
  logic [63:0] in_virt_addr = '0;
  logic [63:0] in_phys_addr = '0;
  logic [63:0] in_byte_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [1:0]  out_status;
  logic [63:0] out_addr;
  logic [63:0] out_bytes;

  // Predictor copies of the two tables.
  bit          vt_used [ENTRIES];
  logic [63:0] vt_vbase [ENTRIES];
  logic [63:0] vt_pbase [ENTRIES];
  logic [63:0] vt_size [ENTRIES];
  bit          pt_used [ENTRIES];
  logic [63:0] pt_pbase [ENTRIES];
  logic [63:0] pt_vbase [ENTRIES];
  logic [63:0] pt_size [ENTRIES];

  answer_t     pending_answers[$];
  int          fail_count = 0;
  int          beats_sent = 0;
  int          beats_checked = 0;
  bit          sink_gaps = 1'b1;

  region_address_translation_table_core #(.TABLE_ENTRIES(ENTRIES)) dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Table searches used by the predictor.
  function automatic int find_vkey(logic [63:0] k);
    for (int i = 0; i < ENTRIES; i++) if (vt_used[i] && vt_vbase[i] == k) return i;
    return -1;
  endfunction

  function automatic int find_pkey(logic [63:0] k);
    for (int i = 0; i < ENTRIES; i++) if (pt_used[i] && pt_pbase[i] == k) return i;
    return -1;
  endfunction

  function automatic int free_vslot();
    for (int i = 0; i < ENTRIES; i++) if (!vt_used[i]) return i;
    return -1;
  endfunction

  function automatic int free_pslot();
    for (int i = 0; i < ENTRIES; i++) if (!pt_used[i]) return i;
    return -1;
  endfunction

  function automatic int vfloor(logic [63:0] a);
    int best;
    best = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (vt_used[i] && vt_vbase[i] <= a && (best < 0 || vt_vbase[i] > vt_vbase[best]))
        best = i;
    return best;
  endfunction

  function automatic int pfloor(logic [63:0] a);
    int best;
    best = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (pt_used[i] && pt_pbase[i] <= a && (best < 0 || pt_pbase[i] > pt_pbase[best]))
        best = i;
    return best;
  endfunction

  function automatic int vnext(logic [63:0] a);
    int best;
    best = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (vt_used[i] && vt_vbase[i] > a && (best < 0 || vt_vbase[i] < vt_vbase[best]))
        best = i;
    return best;
  endfunction

  function automatic void write_pentry(int s, logic [63:0] pb, logic [63:0] vb,
                                       logic [63:0] n);
    pt_used[s] = 1'b1;
    pt_pbase[s] = pb;
    pt_vbase[s] = vb;
    pt_size[s] = n;
  endfunction

  // Applies one command to the table copies and returns the expected result.
  function automatic answer_t translate_command(logic [2:0] cmd, logic [63:0] va,
                                                logic [63:0] pa, logic [63:0] n);
    answer_t r;
    int v, p, s;
    logic [63:0] off, room;
    r.status = STAT_OK;
    r.addr = '0;
    r.bytes = '0;
    case (cmd)
      CMD_REGISTER: begin
        if (find_vkey(va) < 0) begin
          s = vnext(va);
          if (s >= 0 && va + n > vt_vbase[s]) begin
            r.status = STAT_INVAL;
          end else begin
            v = free_vslot();
            p = find_pkey(pa);
            if (p < 0) p = free_pslot();
            if (v < 0 || p < 0) begin
              r.status = STAT_FULL;
            end else begin
              vt_used[v] = 1'b1;
              vt_vbase[v] = va;
              vt_pbase[v] = pa;
              vt_size[v] = n;
              write_pentry(p, pa, va, n);
            end
          end
        end
      end
      CMD_UPDATE: begin
        v = find_vkey(va);
        p = (v < 0) ? -1 : find_pkey(vt_pbase[v]);
        if (v < 0 || p < 0) begin
          r.status = STAT_INVAL;
        end else if (pt_pbase[p] == pa) begin
          pt_size[p] = n;
          vt_size[v] = n;
        end else begin
          pt_used[p] = 1'b0;
          s = find_pkey(pa);
          if (s < 0) s = p;
          write_pentry(s, pa, va, n);
          vt_pbase[v] = pa;
          vt_size[v] = n;
        end
      end
      CMD_UNREGISTER: begin
        v = find_vkey(va);
        if (v < 0) begin
          r.status = STAT_MISS;
        end else begin
          p = find_pkey(vt_pbase[v]);
          if (p >= 0) pt_used[p] = 1'b0;
          vt_used[v] = 1'b0;
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < ENTRIES; i++) begin
          vt_used[i] = 1'b0;
          pt_used[i] = 1'b0;
        end
      end
      CMD_CHECK, CMD_V2P: begin
        v = vfloor(va);
        if (v < 0) begin
          r.status = STAT_MISS;
        end else begin
          off = va - vt_vbase[v];
          if (off >= vt_size[v]) begin
            r.status = STAT_MISS;
          end else if (cmd == CMD_V2P) begin
            room = vt_size[v] - off;
            r.addr = vt_pbase[v] + off;
            r.bytes = (n > room) ? room : n;
          end
        end
      end
      CMD_P2V: begin
        p = pfloor(pa);
        if (p < 0) begin
          r.status = STAT_MISS;
        end else begin
          off = pa - pt_pbase[p];
          if (off >= pt_size[p]) r.status = STAT_MISS;
          else r.addr = pt_vbase[p] + off;
        end
      end
      default: r.status = STAT_INVAL;
    endcase
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int gap_length();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3);
  endfunction

  // Sends one command beat and records the expected result on acceptance.
  // Valid is dropped only for a gap, so back to back beats see one update.
  task automatic send_beat(logic [2:0] cmd, logic [63:0] va, logic [63:0] pa,
                           logic [63:0] n, bit with_gap = 1'b1);
    int gap;
    gap = with_gap ? gap_length() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_virt_addr <= va;
    in_phys_addr <= pa;
    in_byte_count <= n;
    do @(posedge clk); while (in_stall);
    pending_answers.push_back(translate_command(cmd, va, pa, n));
    beats_sent++;
  endtask

  // Result side: random stall and a field by field comparison.
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid && !out_stall) begin
      beats_checked++;
      if (pending_answers.size() == 0) begin
        $error("result beat with no command waiting for it");
        fail_count++;
      end else begin
        want = pending_answers.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
        if (out_addr !== want.addr) begin
          $error("out_addr: expected %h, got %h", want.addr, out_addr);
          fail_count++;
        end
        if (out_bytes !== want.bytes) begin
          $error("out_bytes: expected %h, got %h", want.bytes, out_bytes);
          fail_count++;
        end
      end
    end
    out_stall <= sink_gaps ? (gap_length() != 0) : 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Directed: field extremes, every command and each corner case.
  task automatic test_directed();
    send_beat(CMD_CHECK, '0, '0, '0);
    send_beat(CMD_V2P, '1, '1, '1);
    send_beat(CMD_P2V, '1, '1, '1);
    send_beat(CMD_UNREGISTER, 64'h1000, '0, '0);
    send_beat(CMD_UPDATE, 64'h1000, '0, '0);
    send_beat(CMD_UNUSED, '1, '1, '1);
    send_beat(CMD_REGISTER, 64'h2000, 64'h9000, 64'h100);
    send_beat(CMD_REGISTER, 64'h2000, 64'h5000, 64'h50);
    send_beat(CMD_REGISTER, 64'h1f00, 64'h8000, 64'h101);
    send_beat(CMD_REGISTER, 64'h1f00, 64'h8000, 64'h100);
    send_beat(CMD_REGISTER, 64'h3000, 64'h9000, 64'h40);
    send_beat(CMD_V2P, 64'h2080, '0, 64'h1000);
    send_beat(CMD_V2P, 64'h2080, '0, 64'h10);
    send_beat(CMD_V2P, 64'h2100, '0, 64'h10);
    send_beat(CMD_P2V, '0, 64'h9010, '0);
    send_beat(CMD_CHECK, 64'h1f80, '0, '0);
    send_beat(CMD_REGISTER, 64'hffff_ffff_ffff_ff00, '1, '1);
    send_beat(CMD_V2P, '1, '0, '1);
    send_beat(CMD_UPDATE, 64'h2000, 64'h9000, 64'h20);
    send_beat(CMD_UPDATE, 64'h2000, 64'h8000, 64'h30);
    send_beat(CMD_UPDATE, 64'h3000, 64'h7000, 64'h30);
    send_beat(CMD_UNREGISTER, 64'h1f00, '0, '0);
    send_beat(CMD_CLEAR, '0, '0, '0);
    send_beat(CMD_P2V, '0, 64'h9010, '0);
  endtask

  // Fills both tables until registration reports a full table.
  task automatic test_full_table();
    send_beat(CMD_CLEAR, '0, '0, '0);
    for (int i = 0; i < ENTRIES + 2; i++)
      send_beat(CMD_REGISTER, 64'h10000 * (i + 1), 64'h100 * i, 64'h800);
    send_beat(CMD_REGISTER, 64'h1, 64'h100, 64'h10);
    send_beat(CMD_P2V, '0, 64'h880, '0);
  endtask

  // Random commands on a small address pool so that keys and ranges collide.
  task automatic test_random(int count);
    logic [2:0] cmd;
    logic [63:0] va, pa, n;
    for (int i = 0; i < count; i++) begin
      sink_gaps = ((i / 200) % 3) != 2;
      if ($urandom_range(0, 9) == 0) begin
        va = rand64();
        pa = rand64();
        n = rand64();
      end else begin
        va = 64'h1000 * $urandom_range(0, 24) + ($urandom_range(0, 3) == 0 ?
             $urandom_range(0, 64'h1fff) : 0);
        pa = 64'h1000 * $urandom_range(0, 24) + ($urandom_range(0, 3) == 0 ?
             $urandom_range(0, 64'h1fff) : 0);
        n = $urandom_range(0, 4) == 0 ? rand64() : $urandom_range(0, 64'h1800);
      end
      case ($urandom_range(0, 99)) inside
        [0:29]:  cmd = CMD_REGISTER;
        [30:39]: cmd = CMD_UPDATE;
        [40:49]: cmd = CMD_UNREGISTER;
        [50:51]: cmd = CMD_CLEAR;
        [52:61]: cmd = CMD_CHECK;
        [62:79]: cmd = CMD_V2P;
        [80:97]: cmd = CMD_P2V;
        default: cmd = CMD_UNUSED;
      endcase
      send_beat(cmd, va, pa, n, sink_gaps);
    end
    sink_gaps = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_random(1300);
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d command beats, checked %0d result beats, including full tables,",
             beats_sent, beats_checked);
    $display("overlaps, wrapped sums and clipped translations.");
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  // Timeout guard.
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> sim.f
src/rat_pkg.sv
src/rat_ram.sv
src/rat_ctrl.sv
src/region_address_translation_table_core.sv
src/rat_checker.sv
dv/region_address_translation_table_core_tb.sv
